/* rtl/core/tsr_pkg.sv */
// shared types and constants of the terrain shadow ray marcher
// used by tsr_ctrl, tsr_dpath and terrain_shadow_raymarch_unit; no dependencies
package tsr_pkg;

    // width of a grid coordinate inside the march
    localparam int CoordW = 7;

    // top of the march in 0.1 m units
    localparam logic [16:0] MAX_ELEV = 17'd88480;

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // register indexes on the configuration port
    localparam logic [2:0] REG_SUN_X     = 3'd0;
    localparam logic [2:0] REG_SUN_Y     = 3'd1;
    localparam logic [2:0] REG_SUN_Z     = 3'd2;
    localparam logic [2:0] REG_CELL_DX   = 3'd3;
    localparam logic [2:0] REG_CELL_DY   = 3'd4;
    localparam logic [2:0] REG_ROWS_USED = 3'd5;
    localparam logic [2:0] REG_COLS_USED = 3'd6;

    typedef struct packed {
        logic signed [15:0] sun_x;
        logic signed [15:0] sun_y;
        logic [14:0]        sun_z;
        logic [15:0]        cell_dx;
        logic [15:0]        cell_dy;
        logic [6:0]         rows_used;
        logic [6:0]         cols_used;
    } cfg_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic setup;
        logic step;
        logic fetch;
        logic mult;
        logic judge;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic skip;
        logic go;
    } dp_status_t;

endpackage

/* rtl/core/tsr_ctrl.sv */
// controller state machine of the terrain shadow ray marcher
// depends on tsr_pkg; drives the datapath through tsr_pkg::dp_cmd_t
module tsr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   cmd,
    input  tsr_pkg::dp_status_t    status,
    output tsr_pkg::dp_cmd_t       dp_cmd,
    output logic                   busy,
    output logic                   done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_FETCH,
        ST_MULT,
        ST_JUDGE
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;
    logic   query_ok;

    assign query_ok = start && !busy_reg && (cmd == tsr_pkg::CMD_QUERY);

    // command decode
    always_comb
    begin
        dp_cmd        = '0;
        dp_cmd.accept = (state_reg == ST_IDLE) && query_ok;
        dp_cmd.setup  = (state_reg == ST_SETUP);
        dp_cmd.step   = (state_reg == ST_CHECK) && status.go;
        dp_cmd.fetch  = (state_reg == ST_FETCH);
        dp_cmd.mult   = (state_reg == ST_MULT);
        dp_cmd.judge  = (state_reg == ST_JUDGE);
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (query_ok)
                    begin
                        state_reg <= ST_SETUP;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_SETUP:
                begin
                    if (status.skip)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (status.go)
                    begin
                        state_reg <= ST_FETCH;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                end
                ST_FETCH: state_reg <= ST_MULT;
                ST_MULT:  state_reg <= ST_JUDGE;
                ST_JUDGE: state_reg <= ST_CHECK;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

/* rtl/core/tsr_dpath.sv */
// datapath of the terrain shadow ray marcher: height memory, step counters, multipliers
// depends on tsr_pkg; sequenced by tsr_ctrl
module tsr_dpath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                   clk,
    input  tsr_pkg::cfg_t          cfg,
    input  tsr_pkg::dp_cmd_t       dp_cmd,
    input  logic                   wr_en,
    input  logic [5:0]             row,
    input  logic [5:0]             col,
    input  logic signed [17:0]     elevation,
    output tsr_pkg::dp_status_t    status,
    output logic                   in_shadow,
    output logic [5:0]             result_row,
    output logic [5:0]             result_col
);

    localparam int Depth = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(Depth);
    localparam int CW    = tsr_pkg::CoordW;

    // height memory
    logic signed [17:0] mem [Depth];
    logic signed [17:0] rd_a_reg;
    logic signed [17:0] rd_b_reg;
    logic [AW-1:0]      rd_a_addr;
    logic [AW-1:0]      rd_b_addr;
    logic [AW-1:0]      wr_addr;

    // per-query setup
    logic [5:0]    row_reg;
    logic [5:0]    col_reg;
    logic          rows_major_reg;
    logic [16:0]   a_reg;
    logic [16:0]   b_reg;
    logic [15:0]   dp_reg;
    logic [15:0]   dq_reg;
    logic [14:0]   az_reg;
    logic          op_neg_reg;
    logic          oq_zero_reg;
    logic          oq_neg_reg;
    logic [CW-1:0] nmaj_reg;
    logic [CW-1:0] nmin_reg;
    logic          skip_reg;

    // derived constants of the query
    logic [32:0]        dqa_reg;
    logic [32:0]        dpb_reg;
    logic [30:0]        dpaz_reg;
    logic [30:0]        dqaz_reg;
    logic [33:0]        lim_a_reg;
    logic [33:0]        lim_b_reg;
    logic signed [35:0] z0a_reg;
    logic signed [35:0] z0b_reg;

    // march state
    logic [CW-1:0]      mp_reg;
    logic [CW-1:0]      mq_reg;
    logic [39:0]        pc_reg;
    logic [39:0]        qc_reg;
    logic [37:0]        zp_reg;
    logic [37:0]        zq_reg;
    logic               major_reg;
    logic signed [33:0] num_reg;
    logic signed [39:0] zn_reg;
    logic [33:0]        lim_reg;
    logic signed [51:0] p1_reg;
    logic signed [52:0] p2_reg;
    logic signed [56:0] p3_reg;
    logic               shadow_reg;

    // accept-time decode of the sun vector
    logic [16:0]   ax;
    logic [16:0]   ay;
    logic          rows_major_c;
    logic [15:0]   dx_c;
    logic [15:0]   dy_c;
    logic [CW-1:0] nr_c;
    logic [CW-1:0] nc_c;
    logic [15:0]   minor_c;

    // step and interpolation terms
    logic               major_c;
    logic [CW-1:0]      p2_coord;
    logic [CW-1:0]      q2_coord;
    logic signed [33:0] num_c;
    logic signed [39:0] zn_c;
    logic signed [18:0] dz;
    logic signed [33:0] coef_s;
    logic signed [16:0] scale_s;
    logic signed [51:0] p1_c;
    logic signed [52:0] p2_c;
    logic signed [56:0] p3_c;
    logic signed [57:0] lhs;
    logic signed [57:0] rhs;
    logic               in_bounds;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        cell_addr = AW'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    function automatic logic [CW-1:0] nudge(input logic [CW-1:0] v, input logic zero,
                                            input logic neg);
        nudge = zero ? v : (neg ? v - CW'(1) : v + CW'(1));
    endfunction

    // sun vector magnitudes and axis choice
    assign ax = cfg.sun_x[15] ? (17'd0 - {cfg.sun_x[15], cfg.sun_x}) : {1'b0, cfg.sun_x};
    assign ay = cfg.sun_y[15] ? (17'd0 - {cfg.sun_y[15], cfg.sun_y}) : {1'b0, cfg.sun_y};
    assign rows_major_c = !(ax > ay);
    assign minor_c      = rows_major_c ? cfg.sun_x : cfg.sun_y;
    assign dx_c = (cfg.cell_dx == 16'd0) ? 16'd1 : cfg.cell_dx;
    assign dy_c = (cfg.cell_dy == 16'd0) ? 16'd1 : cfg.cell_dy;
    assign nr_c = (32'(cfg.rows_used) > MAX_ROWS) ? CW'(MAX_ROWS) : cfg.rows_used;
    assign nc_c = (32'(cfg.cols_used) > MAX_COLS) ? CW'(MAX_COLS) : cfg.cols_used;

    // next crossing: major line when it comes strictly first
    assign major_c = (pc_reg + 40'(dpb_reg)) < (qc_reg + 40'(dqa_reg));

    // loop condition
    assign in_bounds = (mp_reg >= CW'(1)) && ((8'(mp_reg) + 8'd2) <= 8'(nmaj_reg))
                    && (mq_reg >= CW'(1)) && ((8'(mq_reg) + 8'd2) <= 8'(nmin_reg));
    assign status.go   = !shadow_reg && (zn_reg < $signed({6'd0, lim_reg})) && in_bounds;
    assign status.skip = skip_reg;

    // second node of the crossed grid line
    assign p2_coord = major_reg ? mp_reg : nudge(mp_reg, 1'b0, op_neg_reg);
    assign q2_coord = major_reg ? nudge(mq_reg, oq_zero_reg, oq_neg_reg) : mq_reg;

    // memory addresses
    always_comb
    begin
        if (dp_cmd.fetch)
        begin
            rd_a_addr = rows_major_reg ? cell_addr(mp_reg, mq_reg) : cell_addr(mq_reg, mp_reg);
        end
        else
        begin
            rd_a_addr = cell_addr({1'b0, row}, {1'b0, col});
        end
        rd_b_addr = rows_major_reg ? cell_addr(p2_coord, q2_coord)
                                   : cell_addr(q2_coord, p2_coord);
    end
    assign wr_addr = cell_addr({1'b0, row}, {1'b0, col});

    // memory write and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en && (32'(row) < MAX_ROWS) && (32'(col) < MAX_COLS))
        begin
            mem[wr_addr] <= elevation;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    // interpolation terms
    assign num_c = major_reg ? 34'(pc_reg - qc_reg) : 34'(qc_reg - pc_reg);
    assign zn_c  = major_reg ? (z0a_reg + $signed({2'b00, zp_reg}))
                             : (z0b_reg + $signed({2'b00, zq_reg}));
    assign dz      = rd_b_reg - rd_a_reg;
    assign coef_s  = $signed({1'b0, (major_reg ? dqa_reg : dpb_reg)});
    assign scale_s = $signed({1'b0, (major_reg ? dq_reg : dp_reg)});
    assign p1_c    = rd_a_reg * coef_s;
    assign p2_c    = dz * num_reg;
    assign p3_c    = zn_reg * scale_s;
    assign lhs     = p1_reg + p2_reg;
    assign rhs     = p3_reg;

    // query sequencing
    always_ff @(posedge clk)
    begin
        if (dp_cmd.accept)
        begin
            row_reg        <= row;
            col_reg        <= col;
            rows_major_reg <= rows_major_c;
            a_reg          <= rows_major_c ? ay : ax;
            b_reg          <= rows_major_c ? ax : ay;
            dp_reg         <= rows_major_c ? dy_c : dx_c;
            dq_reg         <= rows_major_c ? dx_c : dy_c;
            az_reg         <= cfg.sun_z;
            op_neg_reg     <= rows_major_c ? cfg.sun_y[15] : cfg.sun_x[15];
            oq_zero_reg    <= (minor_c == 16'd0);
            oq_neg_reg     <= minor_c[15];
            nmaj_reg       <= rows_major_c ? nr_c : nc_c;
            nmin_reg       <= rows_major_c ? nc_c : nr_c;
            mp_reg         <= rows_major_c ? {1'b0, row} : {1'b0, col};
            mq_reg         <= rows_major_c ? {1'b0, col} : {1'b0, row};
            skip_reg       <= ((cfg.sun_x == 16'sd0) && (cfg.sun_y == 16'sd0))
                           || ({1'b0, row} >= nr_c) || ({1'b0, col} >= nc_c);
        end

        // constants of the query and start of the ray
        if (dp_cmd.setup)
        begin
            dqa_reg    <= dq_reg * a_reg;
            dpb_reg    <= dp_reg * b_reg;
            dpaz_reg   <= dp_reg * az_reg;
            dqaz_reg   <= dq_reg * az_reg;
            lim_a_reg  <= tsr_pkg::MAX_ELEV * a_reg;
            lim_b_reg  <= tsr_pkg::MAX_ELEV * b_reg;
            z0a_reg    <= rd_a_reg * $signed({1'b0, a_reg});
            z0b_reg    <= rd_a_reg * $signed({1'b0, b_reg});
            zn_reg     <= 40'(rd_a_reg);
            lim_reg    <= 34'(tsr_pkg::MAX_ELEV);
            pc_reg     <= '0;
            qc_reg     <= '0;
            zp_reg     <= '0;
            zq_reg     <= '0;
            major_reg  <= 1'b1;
            shadow_reg <= 1'b0;
        end

        // advance to the next crossing
        if (dp_cmd.step)
        begin
            major_reg <= major_c;
            if (major_c)
            begin
                pc_reg <= pc_reg + 40'(dpb_reg);
                zp_reg <= zp_reg + 38'(dpaz_reg);
                mp_reg <= nudge(mp_reg, 1'b0, op_neg_reg);
            end
            else
            begin
                qc_reg <= qc_reg + 40'(dqa_reg);
                zq_reg <= zq_reg + 38'(dqaz_reg);
                mq_reg <= nudge(mq_reg, oq_zero_reg, oq_neg_reg);
            end
        end

        // ray height and crossing offset
        if (dp_cmd.fetch)
        begin
            num_reg <= num_c;
            zn_reg  <= zn_c;
            lim_reg <= major_reg ? lim_a_reg : lim_b_reg;
        end

        if (dp_cmd.mult)
        begin
            p1_reg <= p1_c;
            p2_reg <= p2_c;
            p3_reg <= p3_c;
        end

        // terrain above the ray
        if (dp_cmd.judge)
        begin
            shadow_reg <= (lhs > rhs);
        end
    end

    assign in_shadow  = shadow_reg;
    assign result_row = row_reg;
    assign result_col = col_reg;

endmodule

/* rtl/core/terrain_shadow_raymarch_unit.sv */
// top level of the terrain shadow ray marcher: register port, controller, datapath
// depends on tsr_pkg, tsr_ctrl and tsr_dpath
//
// An elevation write (cmd 0) gives no result; busy stays low.
// A query (cmd 1) raises busy until the ray leaves the interior, climbs past
// 8848 m or meets terrain; a query with the sun at the zenith or a pixel outside
// the used grid holds busy for a single cycle. The ray crosses at most rows_used +
// cols_used grid lines. Each crossing runs through the sequencer states step,
// memory read, multiply and compare, in that order. The result shows on in_shadow,
// result_row and result_col with done high for exactly one cycle, in the cycle busy
// drops; it must be taken then, as the block cannot be stalled. A new item may be
// started in that same cycle. Heights of cells never written are undefined.
module terrain_shadow_raymarch_unit #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [5:0]         row,
    input  logic [5:0]         col,
    input  logic signed [17:0] elevation,
    output logic               done,
    output logic               in_shadow,
    output logic [5:0]         result_row,
    output logic [5:0]         result_col,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    tsr_pkg::cfg_t       cfg;
    tsr_pkg::dp_cmd_t    dp_cmd;
    tsr_pkg::dp_status_t status;

    logic signed [15:0] sun_x_reg;
    logic signed [15:0] sun_y_reg;
    logic [14:0]        sun_z_reg;
    logic [15:0]        cell_dx_reg;
    logic [15:0]        cell_dy_reg;
    logic [6:0]         rows_used_reg;
    logic [6:0]         cols_used_reg;
    logic               cfg_wr;
    logic [2:0]         reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sun_x_reg     <= '0;
            sun_y_reg     <= '0;
            sun_z_reg     <= '0;
            cell_dx_reg   <= 16'd10;
            cell_dy_reg   <= 16'd10;
            rows_used_reg <= 7'd64;
            cols_used_reg <= 7'd64;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                tsr_pkg::REG_SUN_X:     sun_x_reg     <= pwdata[15:0];
                tsr_pkg::REG_SUN_Y:     sun_y_reg     <= pwdata[15:0];
                tsr_pkg::REG_SUN_Z:     sun_z_reg     <= pwdata[14:0];
                tsr_pkg::REG_CELL_DX:   cell_dx_reg   <= pwdata[15:0];
                tsr_pkg::REG_CELL_DY:   cell_dy_reg   <= pwdata[15:0];
                tsr_pkg::REG_ROWS_USED: rows_used_reg <= pwdata[6:0];
                tsr_pkg::REG_COLS_USED: cols_used_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            tsr_pkg::REG_SUN_X:     prdata = {16'd0, sun_x_reg};
            tsr_pkg::REG_SUN_Y:     prdata = {16'd0, sun_y_reg};
            tsr_pkg::REG_SUN_Z:     prdata = {17'd0, sun_z_reg};
            tsr_pkg::REG_CELL_DX:   prdata = {16'd0, cell_dx_reg};
            tsr_pkg::REG_CELL_DY:   prdata = {16'd0, cell_dy_reg};
            tsr_pkg::REG_ROWS_USED: prdata = {25'd0, rows_used_reg};
            tsr_pkg::REG_COLS_USED: prdata = {25'd0, cols_used_reg};
            default:                prdata = '0;
        endcase
    end

    assign cfg.sun_x     = sun_x_reg;
    assign cfg.sun_y     = sun_y_reg;
    assign cfg.sun_z     = sun_z_reg;
    assign cfg.cell_dx   = cell_dx_reg;
    assign cfg.cell_dy   = cell_dy_reg;
    assign cfg.rows_used = rows_used_reg;
    assign cfg.cols_used = cols_used_reg;

    // elevation writes go straight to the memory
    assign wr_en = start && !busy && (cmd == tsr_pkg::CMD_WRITE);

    tsr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .status (status),
        .dp_cmd (dp_cmd),
        .busy   (busy),
        .done   (done)
    );

    tsr_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .clk        (clk),
        .cfg        (cfg),
        .dp_cmd     (dp_cmd),
        .wr_en      (wr_en),
        .row        (row),
        .col        (col),
        .elevation  (elevation),
        .status     (status),
        .in_shadow  (in_shadow),
        .result_row (result_row),
        .result_col (result_col)
    );

endmodule
